### sv/prrts_pkg.sv
`timescale 1ns / 1ps
// Package for the priority round-robin task scheduler.
// Command, result, slot state and scan phase codes; controller interface structs.
package prrts_pkg;

  localparam logic [3:0] CMD_ADD      = 4'd0;
  localparam logic [3:0] CMD_REMOVE   = 4'd1;
  localparam logic [3:0] CMD_RM_FN    = 4'd2;
  localparam logic [3:0] CMD_SET_PRI  = 4'd3;
  localparam logic [3:0] CMD_SUSPEND  = 4'd4;
  localparam logic [3:0] CMD_RESUME   = 4'd5;
  localparam logic [3:0] CMD_SLEEP    = 4'd6;
  localparam logic [3:0] CMD_RUN_ONCE = 4'd7;
  localparam logic [3:0] CMD_RUN_ALL  = 4'd8;

  localparam logic [2:0] RES_ACK     = 3'd0;
  localparam logic [2:0] RES_GRANT   = 3'd1;
  localparam logic [2:0] RES_ADD_OK  = 3'd2;
  localparam logic [2:0] RES_ADD_REF = 3'd3;
  localparam logic [2:0] RES_NONE    = 3'd4;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_SLEEP = 2'd2;
  localparam logic [1:0] ST_SUSP  = 2'd3;

  localparam logic [1:0] BAND_NORMAL = 2'd1;
  localparam logic [1:0] BAND_TOP    = 2'd3;

  localparam logic [2:0] PH_ADD  = 3'd0;
  localparam logic [2:0] PH_RMFN = 3'd1;
  localparam logic [2:0] PH_ONCE = 3'd2;
  localparam logic [2:0] PH_TICK = 3'd3;
  localparam logic [2:0] PH_BAND = 3'd4;

  localparam int MAX_RESULTS = 16;
  localparam int GCNT_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic       load;
    logic       scan_init;
    logic       scan_en;
    logic [2:0] phase;
    logic [1:0] band;
    logic       finish;
  } ctrl_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       fk_zero;
    logic       pass_done;
    logic       out_free;
  } status_t;

endpackage

### sv/prrts_ctrl.sv
`timescale 1ns / 1ps
// Controller of the task scheduler: sequences load, slot scan passes and finish.
// Depends on prrts_pkg.
module prrts_ctrl
  import prrts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_fire,
  output logic    idle,
  input  status_t stat,
  output ctrl_t   ctrl
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DISP   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [1:0] band_r, band_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    band_nxt       = band_r;
    ctrl           = '0;
    ctrl.phase     = phase_r;
    ctrl.band      = band_r;
    case (state_r)
      S_IDLE: begin
        ctrl.load = in_fire;
        if (in_fire) state_nxt = S_DISP;
      end
      S_DISP: begin
        ctrl.scan_init = 1'b1;
        state_nxt      = S_SCAN;
        case (stat.cmd)
          CMD_ADD:      begin
            phase_nxt = PH_ADD;
            if (stat.fk_zero) state_nxt = S_FINISH;
          end
          CMD_RM_FN:    begin
            phase_nxt = PH_RMFN;
            if (stat.fk_zero) state_nxt = S_FINISH;
          end
          CMD_RUN_ONCE: phase_nxt = PH_ONCE;
          CMD_RUN_ALL:  phase_nxt = PH_TICK;
          default:      state_nxt = S_FINISH;
        endcase
      end
      S_SCAN: begin
        ctrl.scan_en = 1'b1;
        if (stat.pass_done) begin
          case (phase_r)
            PH_TICK: begin
              phase_nxt      = PH_BAND;
              band_nxt       = BAND_TOP;
              ctrl.scan_init = 1'b1;
            end
            PH_BAND: begin
              if (band_r == 2'd0) begin
                state_nxt = S_FINISH;
              end else begin
                band_nxt       = band_r - 2'd1;
                ctrl.scan_init = 1'b1;
              end
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_FINISH: begin
        ctrl.finish = 1'b1;
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_ADD;
      band_r  <= BAND_TOP;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      band_r  <= band_nxt;
    end
  end

endmodule

### sv/prrts_dp.sv
`timescale 1ns / 1ps
// Datapath of the task scheduler: slot table, cursor, scan counters and result register.
// Depends on prrts_pkg; driven by prrts_ctrl.
module prrts_dp
  import prrts_pkg::*;
#(
  parameter int TASK_SLOTS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [111:0] in_tdata,
  input  ctrl_t        ctrl,
  output status_t      stat,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,
  output logic         out_tlast
);

  localparam int SW = $clog2(TASK_SLOTS);
  localparam logic [SW-1:0] LAST_IDX = SW'(TASK_SLOTS - 1);

  logic [3:0]           cmd_r, id_r;
  logic [31:0]          fk_r, ak_r;
  logic [1:0]           pri_r;
  logic [TIME_BITS-1:0] amt_r;

  logic [1:0]           st_r  [TASK_SLOTS];
  logic [1:0]           bd_r  [TASK_SLOTS];
  logic [TIME_BITS-1:0] sl_r  [TASK_SLOTS];
  logic [31:0]          fn_r  [TASK_SLOTS];
  logic [31:0]          arg_r [TASK_SLOTS];

  logic [SW-1:0] cursor_r, idx_r, cnt_r;
  logic          dup_v_r, emp_v_r, pend_v_r;
  logic [SW-1:0] dup_r, emp_r, pend_r;
  logic [GCNT_W-1:0] gcnt_r;

  logic       out_v_r, out_last_r;
  logic [2:0] out_kind_r;
  logic [3:0] out_slot_r;

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] x);
    return (x == LAST_IDX) ? '0 : x + SW'(1);
  endfunction

  logic          out_free, id_ok, fin, step, hit, stall, last_pass;
  logic [SW-1:0] id_idx, rd_addr;
  logic [1:0]    rd_st, rd_bd;
  logic [TIME_BITS-1:0] rd_sl;
  logic [31:0]   rd_fn, rd_arg;

  logic          we;
  logic [SW-1:0] wa;
  logic [1:0]    w_st;
  logic          w_bd_en, w_sl_en, w_key_en;
  logic [1:0]    w_bd;
  logic [TIME_BITS-1:0] w_sl;

  logic          o_ld, o_last;
  logic [2:0]    o_kind;
  logic [3:0]    o_slot;
  logic [SW-1:0] cursor_nxt;

  assign out_free  = !out_v_r || out_tready;
  assign id_ok     = 32'(id_r) < TASK_SLOTS;
  assign id_idx    = SW'(id_r);
  assign fin       = ctrl.finish && out_free;
  assign rd_addr   = ctrl.finish ? id_idx : idx_r;
  assign rd_st     = st_r[rd_addr];
  assign rd_bd     = bd_r[rd_addr];
  assign rd_sl     = sl_r[rd_addr];
  assign rd_fn     = fn_r[rd_addr];
  assign rd_arg    = arg_r[rd_addr];
  assign last_pass = (cnt_r == LAST_IDX);

  assign hit   = (ctrl.phase == PH_BAND) && (rd_st == ST_READY) && (rd_bd == ctrl.band)
                 && (gcnt_r < GCNT_W'(MAX_RESULTS));
  assign stall = hit && pend_v_r && !out_free;
  assign step  = ctrl.scan_en && !stall;

  assign stat.cmd       = cmd_r;
  assign stat.fk_zero   = (fk_r == 32'd0);
  assign stat.pass_done = step && last_pass;
  assign stat.out_free  = out_free;

  always_comb begin
    we = 1'b0; wa = rd_addr; w_st = rd_st;
    w_bd_en = 1'b0; w_bd = rd_bd; w_sl_en = 1'b0; w_sl = rd_sl; w_key_en = 1'b0;
    o_ld = 1'b0; o_kind = RES_ACK; o_slot = 4'd0; o_last = 1'b1;
    cursor_nxt = cursor_r;
    if (step) begin
      case (ctrl.phase)
        PH_RMFN: begin
          if (rd_st != ST_EMPTY && rd_fn == fk_r) begin
            we = 1'b1; w_st = ST_EMPTY;
          end
        end
        PH_ONCE, PH_TICK: begin
          if (rd_st == ST_SLEEP) begin
            we = 1'b1; w_sl_en = 1'b1;
            if (rd_sl <= amt_r) begin
              w_sl = '0; w_st = ST_READY;
            end else begin
              w_sl = rd_sl - amt_r;
            end
          end
        end
        PH_BAND: begin
          if (hit && pend_v_r) begin
            o_ld = 1'b1; o_kind = RES_GRANT; o_slot = 4'(pend_r); o_last = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (fin) begin
      o_ld = 1'b1;
      case (cmd_r)
        CMD_ADD: begin
          if (fk_r == 32'd0) begin
            o_kind = RES_ADD_REF;
          end else if (dup_v_r) begin
            o_kind = RES_ADD_OK; o_slot = 4'(dup_r);
          end else if (emp_v_r) begin
            o_kind = RES_ADD_OK; o_slot = 4'(emp_r);
            we = 1'b1; wa = emp_r; w_st = ST_READY;
            w_bd_en = 1'b1; w_bd = BAND_NORMAL;
            w_sl_en = 1'b1; w_sl = '0; w_key_en = 1'b1;
            cursor_nxt = wrap_inc(emp_r);
          end else begin
            o_kind = RES_ADD_REF;
          end
        end
        CMD_REMOVE: begin
          if (id_ok && rd_st != ST_EMPTY) begin
            we = 1'b1; w_st = ST_EMPTY;
          end
        end
        CMD_SET_PRI: begin
          if (id_ok && rd_st != ST_EMPTY) begin
            we = 1'b1; w_bd_en = 1'b1; w_bd = pri_r;
          end
        end
        CMD_SUSPEND: begin
          if (id_ok && rd_st == ST_READY) begin
            we = 1'b1; w_st = ST_SUSP;
          end
        end
        CMD_RESUME: begin
          if (id_ok && (rd_st == ST_SUSP || rd_st == ST_SLEEP)) begin
            we = 1'b1; w_st = ST_READY; w_sl_en = 1'b1; w_sl = '0;
          end
        end
        CMD_SLEEP: begin
          if (id_ok && rd_st != ST_EMPTY && amt_r != '0) begin
            we = 1'b1; w_st = ST_SLEEP; w_sl_en = 1'b1; w_sl = amt_r;
          end
        end
        CMD_RUN_ONCE: begin
          if (emp_v_r) begin
            o_kind = RES_GRANT; o_slot = 4'(emp_r);
            cursor_nxt = wrap_inc(emp_r);
          end else begin
            o_kind = RES_NONE;
          end
        end
        CMD_RUN_ALL: begin
          cursor_nxt = wrap_inc(cursor_r);
          if (pend_v_r) begin
            o_kind = RES_GRANT; o_slot = 4'(pend_r);
          end else begin
            o_kind = RES_NONE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) st_r[i] <= ST_EMPTY;
      cursor_r <= '0;
      out_v_r  <= 1'b0;
      dup_v_r  <= 1'b0;
      emp_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
      gcnt_r   <= '0;
    end else begin
      if (we) st_r[wa] <= w_st;
      cursor_r <= cursor_nxt;
      if (o_ld) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      if (ctrl.load) begin
        dup_v_r  <= 1'b0;
        emp_v_r  <= 1'b0;
        pend_v_r <= 1'b0;
        gcnt_r   <= '0;
      end else if (step) begin
        case (ctrl.phase)
          PH_ADD: begin
            if (rd_st != ST_EMPTY && rd_fn == fk_r && rd_arg == ak_r) dup_v_r <= 1'b1;
            if (rd_st == ST_EMPTY) emp_v_r <= 1'b1;
          end
          PH_ONCE: begin
            if (rd_st == ST_READY || (rd_st == ST_SLEEP && rd_sl <= amt_r)) emp_v_r <= 1'b1;
          end
          PH_BAND: begin
            if (hit) begin
              pend_v_r <= 1'b1;
              gcnt_r   <= gcnt_r + GCNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_tdata[3:0];
      id_r  <= in_tdata[7:4];
      fk_r  <= in_tdata[39:8];
      ak_r  <= in_tdata[71:40];
      pri_r <= in_tdata[73:72];
      amt_r <= TIME_BITS'(in_tdata[105:74]);
    end
    if (we && w_bd_en) bd_r[wa] <= w_bd;
    if (we && w_sl_en) sl_r[wa] <= w_sl;
    if (we && w_key_en) begin
      fn_r[wa]  <= fk_r;
      arg_r[wa] <= ak_r;
    end
    if (ctrl.scan_init) begin
      idx_r <= cursor_r;
      cnt_r <= '0;
    end else if (step) begin
      idx_r <= wrap_inc(idx_r);
      cnt_r <= cnt_r + SW'(1);
    end
    if (step) begin
      case (ctrl.phase)
        PH_ADD: begin
          if (rd_st != ST_EMPTY && rd_fn == fk_r && rd_arg == ak_r) dup_r <= idx_r;
          if (rd_st == ST_EMPTY && !emp_v_r) emp_r <= idx_r;
        end
        PH_ONCE: begin
          if ((rd_st == ST_READY || (rd_st == ST_SLEEP && rd_sl <= amt_r)) && !emp_v_r)
            emp_r <= idx_r;
        end
        PH_BAND: begin
          if (hit) pend_r <= idx_r;
        end
        default: ;
      endcase
    end
    if (o_ld) begin
      out_kind_r <= o_kind;
      out_slot_r <= o_slot;
      out_last_r <= o_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_slot_r, out_kind_r};
  assign out_tlast  = out_last_r;

endmodule

### sv/priority_round_robin_task_scheduler_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Contents
// in_     | slave     | tdata: cmd[3:0] task_id[7:4] fn_key[39:8] arg_key[71:40]
//         |           |        priority_req[73:72] time_amount[105:74], zero fill
// out_    | master     | tdata: result_kind[2:0] slot[6:3], zero fill; tlast: last
// Scans visit one slot per cycle: add, remove_by_fn and run_once scan every slot once (add
// and remove_by_fn skip it for a zero fn_key); run_all scans once, then once per band.
// Stalls on out_tready hold the run_all scan while a grant is pending.
// Synchronous active-low reset empties all slots and clears the cursor.
module priority_round_robin_task_scheduler_core
  import prrts_pkg::*;
#(
  parameter int TASK_SLOTS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [111:0] in_tdata,   // cmd, task_id, fn_key, arg_key, priority_req, time_amount
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // result_kind, slot
  output logic         out_tlast
);

  ctrl_t   ctrl;
  status_t stat;
  logic    idle;

  assign in_tready = idle;

  prrts_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_tvalid && idle),
    .idle    (idle),
    .stat    (stat),
    .ctrl    (ctrl)
  );

  prrts_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### test/priority_round_robin_task_scheduler_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the priority round-robin task scheduler core.
// Holds its own slot table predictor; drives commands with random gaps and checks
// every result item against it. Depends on prrts_pkg and the core only.
module priority_round_robin_task_scheduler_core_test;
  import prrts_pkg::*;

  localparam int SLOTS = 16;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [31:0] amount;
    logic [1:0]  prio;
    logic [31:0] arg_key;
    logic [31:0] fn_key;
    logic [3:0]  task_id;
    logic [3:0]  cmd;
  } command_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic       last;
  } reply_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic         out_tlast;

  priority_round_robin_task_scheduler_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  logic [1:0]  tbl_state [SLOTS];
  logic [1:0]  tbl_band [SLOTS];
  logic [31:0] tbl_sleep [SLOTS];
  logic [31:0] tbl_fn [SLOTS];
  logic [31:0] tbl_arg [SLOTS];
  logic [3:0]  tbl_cursor;

  command_t pending_cmds[$];
  reply_t   expected_replies[$];
  int       errors = 0;
  int       accepted_cmds = 0;
  int       checked_replies = 0;
  int       grant_count = 0;
  bit       stim_done = 0;
  bit       hold_off = 0;
  longint   cycles = 0;
  int       tx_gap = 0;
  int       rx_gap = 0;
  int       hold_left = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic void clear_entry(int i);
    tbl_state[i] = ST_EMPTY;
    tbl_band[i] = BAND_NORMAL;
    tbl_sleep[i] = '0;
    tbl_fn[i] = '0;
    tbl_arg[i] = '0;
  endfunction

  function automatic void push_reply(logic [2:0] kind, logic [3:0] slot, logic last);
    reply_t r;
    r.kind = kind;
    r.slot = slot;
    r.last = last;
    expected_replies.push_back(r);
  endfunction

  function automatic void tick_timers(logic [31:0] dt);
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_state[i] == ST_SLEEP) begin
        if (tbl_sleep[i] <= dt) begin
          tbl_sleep[i] = '0;
          tbl_state[i] = ST_READY;
        end else begin
          tbl_sleep[i] = tbl_sleep[i] - dt;
        end
      end
    end
  endfunction

  function automatic void predict_schedule(command_t c);
    int idx;
    logic [3:0] grants [$];
    case (c.cmd)
      CMD_ADD: begin
        if (c.fn_key == 0) begin
          push_reply(RES_ADD_REF, 0, 1);
          return;
        end
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_state[i] != ST_EMPTY && tbl_fn[i] == c.fn_key && tbl_arg[i] == c.arg_key) begin
            push_reply(RES_ADD_OK, i[3:0], 1);
            return;
          end
        end
        for (int i = 0; i < SLOTS; i++) begin
          idx = (tbl_cursor + i) % SLOTS;
          if (tbl_state[idx] == ST_EMPTY) begin
            tbl_fn[idx] = c.fn_key;
            tbl_arg[idx] = c.arg_key;
            tbl_state[idx] = ST_READY;
            tbl_band[idx] = BAND_NORMAL;
            tbl_sleep[idx] = '0;
            tbl_cursor = 4'((idx + 1) % SLOTS);
            push_reply(RES_ADD_OK, idx[3:0], 1);
            return;
          end
        end
        push_reply(RES_ADD_REF, 0, 1);
        return;
      end
      CMD_REMOVE: if (tbl_state[c.task_id] != ST_EMPTY) clear_entry(c.task_id);
      CMD_RM_FN: begin
        if (c.fn_key != 0)
          for (int i = 0; i < SLOTS; i++)
            if (tbl_state[i] != ST_EMPTY && tbl_fn[i] == c.fn_key) clear_entry(i);
      end
      CMD_SET_PRI: if (tbl_state[c.task_id] != ST_EMPTY) tbl_band[c.task_id] = c.prio;
      CMD_SUSPEND: if (tbl_state[c.task_id] == ST_READY) tbl_state[c.task_id] = ST_SUSP;
      CMD_RESUME: begin
        if (tbl_state[c.task_id] == ST_SUSP || tbl_state[c.task_id] == ST_SLEEP) begin
          tbl_sleep[c.task_id] = '0;
          tbl_state[c.task_id] = ST_READY;
        end
      end
      CMD_SLEEP: begin
        if (tbl_state[c.task_id] != ST_EMPTY && c.amount != 0) begin
          tbl_sleep[c.task_id] = c.amount;
          tbl_state[c.task_id] = ST_SLEEP;
        end
      end
      CMD_RUN_ONCE: begin
        tick_timers(c.amount);
        for (int i = 0; i < SLOTS; i++) begin
          idx = (tbl_cursor + i) % SLOTS;
          if (tbl_state[idx] == ST_READY && tbl_fn[idx] != 0) begin
            tbl_cursor = 4'((idx + 1) % SLOTS);
            push_reply(RES_GRANT, idx[3:0], 1);
            return;
          end
        end
        push_reply(RES_NONE, 0, 1);
        return;
      end
      CMD_RUN_ALL: begin
        tick_timers(c.amount);
        for (int b = 3; b >= 0; b--) begin
          for (int i = 0; i < SLOTS; i++) begin
            idx = (tbl_cursor + i) % SLOTS;
            if (tbl_state[idx] == ST_READY && tbl_fn[idx] != 0 && tbl_band[idx] == b[1:0]
                && grants.size() < MAX_RESULTS)
              grants.push_back(idx[3:0]);
          end
        end
        tbl_cursor = tbl_cursor + 4'd1;
        if (grants.size() == 0) begin
          push_reply(RES_NONE, 0, 1);
          return;
        end
        foreach (grants[k]) push_reply(RES_GRANT, grants[k], k == grants.size() - 1);
        return;
      end
      default: ;
    endcase
    push_reply(RES_ACK, 0, 1);
  endfunction

  function automatic command_t make_cmd(logic [3:0] op, logic [3:0] id, logic [31:0] fk,
                                        logic [31:0] ak, logic [1:0] pr, logic [31:0] amt);
    command_t c;
    c.cmd = op;
    c.task_id = id;
    c.fn_key = fk;
    c.arg_key = ak;
    c.prio = pr;
    c.amount = amt;
    return c;
  endfunction

  // Small handle pool so duplicates and remove_by_fn hit often.
  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r < 7) return 32'h1000 + $urandom_range(0, 5);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_ticks();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 20);
    if (r < 7) return 32'hFFFF_FFFF - $urandom_range(0, 3);
    return $urandom();
  endfunction

  function automatic command_t random_cmd();
    int r;
    logic [3:0] op;
    r = $urandom_range(0, 99);
    if (r < 25) op = CMD_ADD;
    else if (r < 35) op = CMD_RUN_ALL;
    else if (r < 45) op = CMD_RUN_ONCE;
    else if (r < 97) op = 4'($urandom_range(1, 6));
    else op = 4'($urandom_range(9, 15));
    return make_cmd(op, 4'($urandom_range(0, 15)), pick_handle(), pick_handle(),
                    2'($urandom_range(0, 3)), pick_ticks());
  endfunction

  initial begin
    // Directed: fill, extremes, every command and corner.
    pending_cmds.push_back(make_cmd(CMD_RUN_ONCE, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RUN_ALL, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD, 0, 0, 5, 0, 0));
    for (int i = 0; i < SLOTS; i++)
      pending_cmds.push_back(make_cmd(CMD_ADD, 0, 32'hFFFF_FFF0 + i, 32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD, 0, 32'h1234, 32'h1, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_ADD, 0, 32'hFFFF_FFF3, 32'hFFFF_FFFF, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SET_PRI, 15, 0, 0, 3, 0));
    pending_cmds.push_back(make_cmd(CMD_SET_PRI, 3, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SET_PRI, 4, 0, 0, 2, 0));
    pending_cmds.push_back(make_cmd(CMD_SUSPEND, 5, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_SLEEP, 6, 0, 0, 0, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_SLEEP, 7, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RUN_ALL, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_RESUME, 5, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_REMOVE, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RM_FN, 0, 32'hFFFF_FFF1, 0, 0, 0));
    pending_cmds.push_back(make_cmd(CMD_RM_FN, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(4'd15, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3,
                                    32'hFFFF_FFFF));
    pending_cmds.push_back(make_cmd(CMD_RUN_ONCE, 0, 0, 0, 0, 1));
    for (int n = 0; n < 300; n++) pending_cmds.push_back(random_cmd());
  end

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    out_tready = 0;
    for (int i = 0; i < SLOTS; i++) clear_entry(i);
    tbl_cursor = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
  end

  // Driver: advance on handshake at the rising edge, present at the falling edge.
  bit in_fire;
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_schedule(command_t'(in_tdata[105:0]));
      accepted_cmds <= accepted_cmds + 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_fire) tx_gap = pick_gap();
      if (!in_tvalid || in_fire) begin
        if (tx_gap > 0) begin
          tx_gap = tx_gap - 1;
          in_tvalid <= 0;
        end else if (pending_cmds.size() > 0) begin
          in_tdata <= {6'd0, pending_cmds.pop_front()};
          in_tvalid <= 1;
        end else begin
          in_tvalid <= 0;
          stim_done = 1;
        end
      end
    end
  end

  // Receiver stall pattern with one long hold-off during the random part.
  always @(negedge clk) begin
    if (rst_n) begin
      if (!hold_off && accepted_cmds == 60) begin
        hold_off = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_tready <= 0;
      end else if (rx_gap > 0) begin
        rx_gap = rx_gap - 1;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if ($urandom_range(0, 3) == 0) rx_gap = pick_gap();
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tdata[2:0];
      got.slot = out_tdata[6:3];
      got.last = out_tlast;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result kind=%0d slot=%0d last=%0d",
                 $time, got.kind, got.slot, got.last);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected kind=%0d slot=%0d last=%0d, got kind=%0d slot=%0d last=%0d",
                   $time, want.kind, want.slot, want.last, got.kind, got.slot, got.last);
          errors++;
        end
        if (got.kind == RES_GRANT) grant_count++;
        checked_replies++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (expected_replies.size() == 0 && !in_tvalid);
    repeat (200) @(posedge clk);
    $display("Ran %0d commands, checked %0d results including %0d grants.",
             accepted_cmds, checked_replies, grant_count);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### priority_round_robin_task_scheduler_core.f
sv/prrts_pkg.sv
sv/prrts_ctrl.sv
sv/prrts_dp.sv
sv/priority_round_robin_task_scheduler_core.sv
test/priority_round_robin_task_scheduler_core_test.sv
